// ===== hdl/tdsa_pkg.sv =====
// shared constants, codes and word types of the transmit descriptor slot allocator
package tdsa_pkg;

    // sizing
    localparam int SLOT_COUNT      = 64;
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int HDR_BYTES       = 12;
    localparam int SCAN_LANES      = 8;
    localparam int QUEUE_DEPTH     = 2;

    // derived widths
    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
    localparam int SUM_W   = $clog2(2 * SLOT_COUNT + SCAN_LANES);
    localparam int LANE_W  = $clog2(SCAN_LANES);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int MINF_W     = 12;
    localparam int LEN_W      = 16;
    localparam int ID_W       = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOTF_W    = 6;
    localparam int DLEN_W     = 12;
    localparam int FREEF_W    = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_READY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME    = 1'd1;
    localparam logic [MINF_W-1:0]    MIN_FRAME_RESET  = 12'd60;

    // request commands
    localparam logic CMD_RESERVE  = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_RESERVED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FREED          = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_READY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_COMPLETION = 3'd5;

    // classified job kinds
    typedef enum logic [1:0] {
        JOB_RESERVE,
        JOB_COMPLETE,
        JOB_REJECT
    } t_job_kind;

    // input word
    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  frame_length;
        logic [ID_W-1:0]   completion_id;
    } t_req;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOTF_W-1:0]  slot;
        logic [DLEN_W-1:0]   descriptor_length;
        logic [FREEF_W-1:0]  free_slots;
    } t_res;

    // classified job between front and back
    typedef struct packed {
        t_job_kind           kind;
        logic [STATUS_W-1:0] rej_status;
        logic                id_ok;
        logic [SLOT_W-1:0]   id;
        logic [DLEN_W-1:0]   dlen;
    } t_job;

endpackage

// ===== hdl/tdsa_front.sv =====
// front end: classifies requests and computes the descriptor length
module tdsa_front (
    input  tdsa_pkg::t_req                    i_req,
    input  logic                              i_device_ready,
    input  logic [tdsa_pkg::MINF_W-1:0]       i_min_frame,
    output tdsa_pkg::t_job                    o_job
);

    logic                            len_ok;
    logic [tdsa_pkg::LEN_W-1:0]      min_ext;
    logic [tdsa_pkg::LEN_W-1:0]      wire_len;
    logic [tdsa_pkg::LEN_W:0]        dsum;

    // length checks and padded descriptor length
    always_comb begin
        len_ok   = (i_req.frame_length != '0) &&
                   (i_req.frame_length <= tdsa_pkg::LEN_W'(tdsa_pkg::MAX_FRAME_BYTES));
        min_ext  = tdsa_pkg::LEN_W'(i_min_frame);
        wire_len = (i_req.frame_length < min_ext) ? min_ext : i_req.frame_length;
        dsum     = (tdsa_pkg::LEN_W + 1)'(wire_len) +
                   (tdsa_pkg::LEN_W + 1)'(tdsa_pkg::HDR_BYTES);
    end

    // classification
    always_comb begin
        o_job.rej_status = tdsa_pkg::ST_NOT_READY;
        o_job.id_ok      = i_req.completion_id < tdsa_pkg::ID_W'(tdsa_pkg::SLOT_COUNT);
        o_job.id         = i_req.completion_id[tdsa_pkg::SLOT_W-1:0];
        o_job.dlen       = (dsum > (tdsa_pkg::LEN_W + 1)'({tdsa_pkg::DLEN_W{1'b1}})) ?
                           {tdsa_pkg::DLEN_W{1'b1}} : dsum[tdsa_pkg::DLEN_W-1:0];
        if (i_req.cmd == tdsa_pkg::CMD_COMPLETE) begin
            o_job.kind = tdsa_pkg::JOB_COMPLETE;
        end else if (!i_device_ready) begin
            o_job.kind = tdsa_pkg::JOB_REJECT;
        end else if (!len_ok) begin
            o_job.kind       = tdsa_pkg::JOB_REJECT;
            o_job.rej_status = tdsa_pkg::ST_BAD_LENGTH;
        end else begin
            o_job.kind = tdsa_pkg::JOB_RESERVE;
        end
    end

endmodule

// ===== hdl/tdsa_cmd_queue.sv =====
// short job queue between front end and back end
module tdsa_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tdsa_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output tdsa_pkg::t_job o_job,
    input  logic           i_pop
);

    tdsa_pkg::t_job                r_mem [tdsa_pkg::QUEUE_DEPTH];
    logic [tdsa_pkg::QPTR_W-1:0]   r_wr;
    logic [tdsa_pkg::QPTR_W-1:0]   r_rd;
    logic [tdsa_pkg::QCNT_W-1:0]   r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == tdsa_pkg::QCNT_W'(tdsa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [tdsa_pkg::QPTR_W-1:0] wrap_inc(
        input logic [tdsa_pkg::QPTR_W-1:0] p
    );
        if (p == tdsa_pkg::QPTR_W'(tdsa_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== hdl/tdsa_back.sv =====
// back end: slot map, free count, round-robin scan and result register
module tdsa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tdsa_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_res_valid,
    output tdsa_pkg::t_res o_res,
    input  logic           i_pop
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                            r_state, n_state;
    logic [tdsa_pkg::SLOT_COUNT-1:0]   r_map, n_map;
    logic [tdsa_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [tdsa_pkg::SLOT_W-1:0]       r_ptr, n_ptr;
    logic [tdsa_pkg::SUM_W-1:0]        r_off, n_off;
    logic [tdsa_pkg::DLEN_W-1:0]       r_dlen, n_dlen;
    tdsa_pkg::t_res                    r_res, n_res;
    tdsa_pkg::t_res                    r_out, n_out;
    logic                              r_out_valid, n_out_valid;

    logic [tdsa_pkg::SUM_W-1:0]        lane_pos [tdsa_pkg::SCAN_LANES];
    logic [tdsa_pkg::SUM_W-1:0]        lane_sum [tdsa_pkg::SCAN_LANES];
    logic [tdsa_pkg::SLOT_W-1:0]       lane_idx [tdsa_pkg::SCAN_LANES];
    logic [tdsa_pkg::SCAN_LANES-1:0]   lane_hit;
    logic [tdsa_pkg::LANE_W-1:0]       sel;
    logic                              found;
    logic [tdsa_pkg::SLOT_W-1:0]       claim;
    logic [tdsa_pkg::SLOT_W-1:0]       claim_next;
    logic [tdsa_pkg::SUM_W-1:0]        off_next;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // one scan step: lanes look at consecutive slots from the search pointer
    always_comb begin
        for (int j = 0; j < tdsa_pkg::SCAN_LANES; j++) begin
            lane_pos[j] = r_off + tdsa_pkg::SUM_W'(j);
            lane_sum[j] = tdsa_pkg::SUM_W'(r_ptr) + lane_pos[j];
            if (lane_sum[j] >= tdsa_pkg::SUM_W'(tdsa_pkg::SLOT_COUNT)) begin
                lane_sum[j] = lane_sum[j] - tdsa_pkg::SUM_W'(tdsa_pkg::SLOT_COUNT);
            end
            lane_idx[j] = lane_sum[j][tdsa_pkg::SLOT_W-1:0];
            lane_hit[j] = (lane_pos[j] < tdsa_pkg::SUM_W'(tdsa_pkg::SLOT_COUNT)) &&
                          !r_map[lane_idx[j]];
        end
        sel = '0;
        for (int j = tdsa_pkg::SCAN_LANES - 1; j >= 0; j--) begin
            if (lane_hit[j]) begin
                sel = tdsa_pkg::LANE_W'(j);
            end
        end
        found      = |lane_hit;
        claim      = lane_idx[sel];
        claim_next = (claim == tdsa_pkg::SLOT_W'(tdsa_pkg::SLOT_COUNT - 1)) ?
                     '0 : claim + 1'b1;
        off_next   = r_off + tdsa_pkg::SUM_W'(tdsa_pkg::SCAN_LANES);
    end

    // job sequencing
    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_off       = r_off;
        n_dlen      = r_dlen;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_q_pop     = 1'b0;
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop                 = 1'b1;
                    n_res.status            = i_q_job.rej_status;
                    n_res.slot              = '0;
                    n_res.descriptor_length = '0;
                    n_res.free_slots        = tdsa_pkg::FREEF_W'(r_count);
                    n_state                 = S_OUT;
                    case (i_q_job.kind)
                        tdsa_pkg::JOB_COMPLETE: begin
                            if (i_q_job.id_ok && r_map[i_q_job.id]) begin
                                n_map[i_q_job.id] = 1'b0;
                                if (r_count < tdsa_pkg::COUNT_W'(tdsa_pkg::SLOT_COUNT)) begin
                                    n_count = r_count + 1'b1;
                                end
                                n_res.status     = tdsa_pkg::ST_FREED;
                                n_res.free_slots = tdsa_pkg::FREEF_W'(n_count);
                            end else begin
                                n_res.status = tdsa_pkg::ST_BAD_COMPLETION;
                            end
                        end
                        tdsa_pkg::JOB_RESERVE: begin
                            if (r_count == '0) begin
                                n_res.status = tdsa_pkg::ST_NO_SLOT;
                            end else begin
                                n_dlen  = i_q_job.dlen;
                                n_off   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_res.status = i_q_job.rej_status;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_res.slot              = '0;
                n_res.descriptor_length = '0;
                n_res.free_slots        = tdsa_pkg::FREEF_W'(r_count);
                if (found) begin
                    n_map[claim]            = 1'b1;
                    n_count                 = r_count - 1'b1;
                    n_ptr                   = claim_next;
                    n_res.status            = tdsa_pkg::ST_RESERVED;
                    n_res.slot              = tdsa_pkg::SLOTF_W'(claim);
                    n_res.descriptor_length = r_dlen;
                    n_res.free_slots        = tdsa_pkg::FREEF_W'(n_count);
                    n_state                 = S_OUT;
                end else if (off_next >= tdsa_pkg::SUM_W'(tdsa_pkg::SLOT_COUNT)) begin
                    // whole ring seen without a free slot, pointer is back where it began
                    n_res.status = tdsa_pkg::ST_NO_SLOT;
                    n_state      = S_OUT;
                end else begin
                    n_off = off_next;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map       <= '0;
            r_count     <= tdsa_pkg::COUNT_W'(tdsa_pkg::SLOT_COUNT);
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
        r_off  <= n_off;
        r_dlen <= n_dlen;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

// ===== hdl/tx_descriptor_slot_allocator_unit.sv =====
// top level of the transmit descriptor slot allocator
// completions, rejects and reserves with no free slot go from S_IDLE through r_res and S_OUT to the result word
// a reserve that claims a slot passes through S_SCAN, where the back end scans 8 map slots per cycle
// the back end takes a new job only in S_IDLE, after its last result is written to the result word
// a 2-word job queue lets requests be accepted while the back end scans or a result waits
// synchronous active-low reset clears the slot map, sets free count to the slot count,
// the search pointer to 0, empties the job queue and the result word and loads the register defaults
module tx_descriptor_slot_allocator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  tdsa_pkg::t_req                    i_req,
    output logic                              empty,
    input  logic                              pop,
    output tdsa_pkg::t_res                    o_res,
    input  logic                              i_cfg_we,
    input  logic [tdsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tdsa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                          r_device_ready;
    logic [tdsa_pkg::MINF_W-1:0]   r_min_frame;
    tdsa_pkg::t_job                front_job;
    tdsa_pkg::t_job                q_job;
    logic                          q_valid;
    logic                          q_pop;
    logic                          res_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_ready <= 1'b0;
            r_min_frame    <= tdsa_pkg::MIN_FRAME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tdsa_pkg::CFG_DEVICE_READY: r_device_ready <= i_cfg_data[0];
                tdsa_pkg::CFG_MIN_FRAME:    r_min_frame    <= i_cfg_data[tdsa_pkg::MINF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request classification
    tdsa_front u_front (
        .i_req          (i_req),
        .i_device_ready (r_device_ready),
        .i_min_frame    (r_min_frame),
        .o_job          (front_job)
    );

    // job queue
    tdsa_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // slot bookkeeping and result word
    tdsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .o_res       (o_res),
        .i_pop       (pop)
    );

    assign empty = !res_valid;

`ifndef SYNTHESIS
    // a reserved slot always carries at least the header plus one byte
    a_reserved_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status == tdsa_pkg::ST_RESERVED) |->
        (o_res.descriptor_length > tdsa_pkg::DLEN_W'(tdsa_pkg::HDR_BYTES)))
        else $error("reserved word with short descriptor length");

    // words other than reserved carry no slot and no length
    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status != tdsa_pkg::ST_RESERVED) |->
        (o_res.slot == '0 && o_res.descriptor_length == '0))
        else $error("slot or length set on a non-reserve word");

    // free count never exceeds the ring size
    a_free_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_res.free_slots <= tdsa_pkg::FREEF_W'(tdsa_pkg::SLOT_COUNT)))
        else $error("free slot count above slot count");

    // a waiting word holds until popped
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("result word changed before pop");
`endif

endmodule
